@@ sv/jsu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Holds the error codes, the command word passed from the parser to the
// output sequencer, and the hex digit decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam logic [3:0] ERR_NONE          = 4'd0;
	localparam logic [3:0] ERR_EXPECT_STRING = 4'd1;
	localparam logic [3:0] ERR_CONTROL_CHAR  = 4'd2;
	localparam logic [3:0] ERR_UNFIN_ESCAPE  = 4'd3;
	localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd4;
	localparam logic [3:0] ERR_UNFIN_UNICODE = 4'd5;
	localparam logic [3:0] ERR_BAD_HEX       = 4'd6;
	localparam logic [3:0] ERR_SURROGATE     = 4'd7;
	localparam logic [3:0] ERR_UNTERMINATED  = 4'd8;

	// One parsed result group: up to three output bytes, or a status word.
	typedef struct packed {
		logic [1:0] cnt;      // number of words to emit, 1..3
		logic       has_data; // words carry decoded bytes
		logic       done;     // closing quote seen
		logic [3:0] err;      // error code, ERR_NONE when fine
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} jsu_cmd_t;

	// Returns {invalid, value}.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else begin
			r = 5'b10000;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/jsu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front: input parser
// Tracks string and escape state one accepted byte per cycle and turns each
// byte that causes output into one command word for the output sequencer.
// ----------------------------------------------------------------------------
module jsu_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       in_byte,
	input  wire logic             end_of_input,
	output logic                  push,
	output jsu_pkg::jsu_cmd_t     cmd
);
	import jsu_pkg::*;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_STR  = 2'd1;
	localparam logic [1:0] MODE_ESC  = 2'd2;
	localparam logic [1:0] MODE_UNI  = 2'd3;

	logic [1:0]  mode_q, mode_d;
	logic [1:0]  hex_q, hex_d;
	logic [11:0] acc_q, acc_d;
	logic [4:0]  hx;
	logic [15:0] cp;
	logic        is_space;

	assign hx       = hex_decode(in_byte);
	assign cp       = {acc_q, hx[3:0]};
	assign is_space = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0d);

	always_comb begin
		mode_d = mode_q;
		hex_d  = hex_q;
		acc_d  = acc_q;
		push   = 1'b0;
		cmd    = '0;
		cmd.cnt = 2'd1;
		if (accept) begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (end_of_input || !(is_space || in_byte == 8'h22)) begin
						push    = 1'b1;
						cmd.err = ERR_EXPECT_STRING;
					end else if (in_byte == 8'h22) begin
						mode_d = MODE_STR;
					end
				end
				MODE_STR: begin
					if (end_of_input) begin
						push    = 1'b1;
						cmd.err = ERR_UNTERMINATED;
						mode_d  = MODE_IDLE;
					end else if (in_byte == 8'h22) begin
						push     = 1'b1;
						cmd.done = 1'b1;
						mode_d   = MODE_IDLE;
					end else if (in_byte < 8'h20) begin
						push    = 1'b1;
						cmd.err = ERR_CONTROL_CHAR;
						mode_d  = MODE_IDLE;
					end else if (in_byte == 8'h5c) begin
						mode_d = MODE_ESC;
					end else begin
						push         = 1'b1;
						cmd.has_data = 1'b1;
						cmd.b0       = in_byte;
					end
				end
				MODE_ESC: begin
					mode_d = MODE_STR;
					if (end_of_input) begin
						push    = 1'b1;
						cmd.err = ERR_UNFIN_ESCAPE;
						mode_d  = MODE_IDLE;
					end else begin
						push         = 1'b1;
						cmd.has_data = 1'b1;
						unique case (in_byte)
							8'h22:   cmd.b0 = 8'h22;
							8'h5c:   cmd.b0 = 8'h5c;
							8'h2f:   cmd.b0 = 8'h2f;
							8'h62:   cmd.b0 = 8'h08;
							8'h66:   cmd.b0 = 8'h0c;
							8'h6e:   cmd.b0 = 8'h0a;
							8'h72:   cmd.b0 = 8'h0d;
							8'h74:   cmd.b0 = 8'h09;
							8'h75: begin
								push         = 1'b0;
								cmd.has_data = 1'b0;
								mode_d       = MODE_UNI;
								hex_d        = 2'd0;
								acc_d        = 12'd0;
							end
							default: begin
								cmd.has_data = 1'b0;
								cmd.err      = ERR_BAD_ESCAPE;
								mode_d       = MODE_IDLE;
							end
						endcase
					end
				end
				default: begin
					if (end_of_input || hx[4]) begin
						push    = 1'b1;
						cmd.err = end_of_input ? ERR_UNFIN_UNICODE : ERR_BAD_HEX;
						mode_d  = MODE_IDLE;
					end else if (hex_q != 2'd3) begin
						acc_d = {acc_q[7:0], hx[3:0]};
						hex_d = hex_q + 2'd1;
					end else if (cp[15:11] == 5'b11011) begin
						push    = 1'b1;
						cmd.err = ERR_SURROGATE;
						mode_d  = MODE_IDLE;
					end else begin
						push         = 1'b1;
						cmd.has_data = 1'b1;
						mode_d       = MODE_STR;
						if (cp <= 16'h007f) begin
							cmd.b0 = cp[7:0];
						end else if (cp <= 16'h07ff) begin
							cmd.cnt = 2'd2;
							cmd.b0  = 8'hc0 | {3'b000, cp[10:6]};
							cmd.b1  = 8'h80 | {2'b00, cp[5:0]};
						end else begin
							cmd.cnt = 2'd3;
							cmd.b0  = 8'he0 | {4'b0000, cp[15:12]};
							cmd.b1  = 8'h80 | {2'b00, cp[11:6]};
							cmd.b2  = 8'h80 | {2'b00, cp[5:0]};
						end
					end
				end
			endcase
			// Leaving a unicode escape or a string clears the digit state.
			if (mode_d != MODE_UNI) begin
				hex_d = 2'd0;
				acc_d = 12'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hex_q  <= 2'd0;
			acc_q  <= 12'd0;
		end else begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
			acc_q  <= acc_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/jsu_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_fifo: command queue
// Small first-in first-out buffer of parsed commands between parser and
// output sequencer.
// ----------------------------------------------------------------------------
module jsu_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire jsu_pkg::jsu_cmd_t push_data,
	input  wire logic              pop,
	output jsu_pkg::jsu_cmd_t      pop_data,
	output logic                   full,
	output logic                   empty
);
	import jsu_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_cmd_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/jsu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back: output sequencer
// Expands each queued command into one to three output words and holds them
// in the output register until the sink takes them.
// ----------------------------------------------------------------------------
module jsu_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jsu_pkg::jsu_cmd_t cmd,
	input  wire logic              cmd_empty,
	output logic                   cmd_pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,
	output logic [5:0]             m_tuser,
	output logic                   m_tlast
);
	import jsu_pkg::*;

	logic       valid_q;
	logic [1:0] beat_q;
	logic [7:0] data_q;
	logic [5:0] user_q;
	logic       last_q;
	logic       load;
	logic       final_beat;
	logic [7:0] beat_byte;

	assign load       = !valid_q || m_tready;
	assign final_beat = (beat_q == cmd.cnt - 2'd1);
	assign cmd_pop    = load && !cmd_empty && final_beat;

	always_comb begin
		case (beat_q)
			2'd0:    beat_byte = cmd.b0;
			2'd1:    beat_byte = cmd.b1;
			default: beat_byte = cmd.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= 2'd0;
		end else if (load) begin
			valid_q <= !cmd_empty;
			if (!cmd_empty) begin
				beat_q <= final_beat ? 2'd0 : beat_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !cmd_empty) begin
			data_q <= cmd.has_data ? beat_byte : 8'h00;
			user_q <= {cmd.err, cmd.done, cmd.has_data};
			last_q <= final_beat;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

@@ sv/json_string_unescaper.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescaper: streaming JSON string decoder
// Decodes one quoted JSON string at a time from a byte stream.
// ----------------------------------------------------------------------------
// Feed the JSON text one byte per word on the slave side; set s_tlast on a
// word to say the text has ended (its data byte is then ignored). Leading
// whitespace is skipped, a double quote opens the string, and decoded bytes
// leave on the master side, flagged in m_tuser with string done or an error
// code. A \u escape yields one to three UTF-8 words; every other input byte
// that produces output yields exactly one word, and m_tlast marks the last
// word caused by an input byte. After an error or a closing quote the block
// is back outside any string. The parser takes one byte per cycle while the
// FIFO_DEPTH-entry command queue has a free slot; the output sequencer sends
// one word per cycle while the sink is ready, so a multibyte \u result holds
// the output side for its two or three words while the parser keeps running
// ahead into that queue. Words pass through it and then the output register.
// ----------------------------------------------------------------------------
module json_string_unescaper #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] in_byte
	input  wire logic       s_tlast,  // end_of_input
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // [7:0] out_byte
	output logic [5:0]      m_tuser,  // [0] out_valid, [1] string_done, [5:2] error_code
	output logic            m_tlast   // last word for this input byte
);
	import jsu_pkg::*;

	logic     accept;
	logic     push;
	jsu_cmd_t push_cmd;
	jsu_cmd_t head_cmd;
	logic     q_full, q_empty, q_pop;

	// Take a byte whenever the queue has a free slot.
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (s_tdata),
		.end_of_input (s_tlast),
		.push         (push),
		.cmd          (push_cmd)
	);

	jsu_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (q_pop),
		.pop_data  (head_cmd),
		.full      (q_full),
		.empty     (q_empty)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
